>>> src/kcm_pkg.sv
// kcm_pkg: shared constants and types of the key chord matcher
// no dependencies; used by the interfaces, the top level and the checker

package kcm_pkg;

  localparam int HELD_DEPTH     = 8;
  localparam int CHORD_COUNT    = 8;
  localparam int KEYS_PER_CHORD = 6;
  localparam int CODE_BITS      = 10;

  localparam int KEY_CODE_W     = 10;
  localparam int KEY_VALUE_W    = 2;
  localparam int CHORD_IDX_W    = 3;
  localparam int HELD_COUNT_W   = 4;

  localparam int NUM_CHORD_REGS = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int CHORD_CNT_LSB  = 60;
  localparam int CHORD_CNT_W    = 4;

  localparam int HELD_IDX_W     = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
  localparam int HELD_CNT_W     = $clog2(HELD_DEPTH + 1);
  localparam int HELD_CNT_MAX   = (HELD_DEPTH > 15) ? 15 : HELD_DEPTH;

  typedef logic [KEY_CODE_W-1:0]   key_code_t;
  typedef logic [KEY_VALUE_W-1:0]  key_value_t;
  typedef logic [CHORD_IDX_W-1:0]  chord_idx_t;
  typedef logic [HELD_COUNT_W-1:0] held_count_t;
  typedef logic [CODE_BITS-1:0]    code_t;

endpackage

>>> src/kcm_if.sv
// kcm_if: valid/ready channels for key events and match results
// depends on kcm_pkg

interface kcm_evt_if;
  logic                 valid;
  logic                 ready;
  kcm_pkg::key_code_t   key_code;
  kcm_pkg::key_value_t  key_value;

  modport source (output valid, key_code, key_value, input ready);
  modport sink   (input valid, key_code, key_value, output ready);
endinterface

interface kcm_res_if;
  logic                  valid;
  logic                  ready;
  logic                  fired;
  kcm_pkg::chord_idx_t   chord_index;
  logic                  last_result;
  kcm_pkg::held_count_t  held_count;
  logic                  overflow;

  modport source (output valid, fired, chord_index, last_result, held_count, overflow,
                  input ready);
  modport sink   (input valid, fired, chord_index, last_result, held_count, overflow,
                  output ready);
endinterface

>>> src/kcm_ram.sv
// kcm_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies

module kcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/key_chord_matcher.sv
// key_chord_matcher: held key set tracking and chord matching, top level
// depends on kcm_pkg, kcm_if and kcm_ram
//
// Each key event walks the held-code ram once, one entry per cycle, comparing every held
// code against every chord code and the event code at the same time; the set update is
// then written back and the matches are sent as one item per matching chord (or a single
// item with fired clear). An event keeps the block busy through the scan, the update, the match
// step and one emit step per result item (1 to CHORD_COUNT items), an emit waiting while the output
// register is full; the walk over the single read port of the held-code ram sets the scan. A new event is
// taken while the last result item still waits in the output register. Chord registers
// may be written whenever no event is in flight.

module key_chord_matcher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  kcm_evt_if.sink                          evt_i,
  kcm_res_if.source                        res_o,
  input  logic                             cfg_we_i,
  input  logic [kcm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kcm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int ScanCntW = $clog2(kcm_pkg::HELD_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_UPDATE = 5'b00100,
    ST_MATCH  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  typedef logic [kcm_pkg::CHORD_COUNT-1:0][kcm_pkg::KEYS_PER_CHORD-1:0] found_t;

  state_e                                state_q, state_d;
  logic [kcm_pkg::CFG_DATA_W-1:0]        chord_q [kcm_pkg::CHORD_COUNT];
  logic [kcm_pkg::HELD_DEPTH-1:0]        held_valid_q, held_valid_d;
  kcm_pkg::code_t                        code_q, code_d;
  logic                                  press_q, press_d;
  logic [ScanCntW-1:0]                   scan_cnt_q, scan_cnt_d;
  logic [ScanCntW-1:0]                   scan_prev;
  logic [kcm_pkg::HELD_IDX_W-1:0]        scan_idx;
  found_t                                found_q, found_d;
  logic                                  hit_q, hit_d;
  logic [kcm_pkg::HELD_IDX_W-1:0]        pos_q, pos_d;
  logic                                  ovf_q, ovf_d;
  kcm_pkg::held_count_t                  hc_q, hc_d;
  logic [kcm_pkg::CHORD_COUNT-1:0]       rem_q, rem_d;

  logic                                  out_valid_q, out_valid_d;
  logic                                  out_fired_q, out_fired_d;
  kcm_pkg::chord_idx_t                   out_idx_q, out_idx_d;
  logic                                  out_last_q, out_last_d;
  kcm_pkg::held_count_t                  out_hc_q, out_hc_d;
  logic                                  out_ovf_q, out_ovf_d;

  logic                                  ram_we;
  logic [kcm_pkg::HELD_IDX_W-1:0]        free_slot;
  logic                                  has_free;
  logic                                  do_insert;
  logic                                  do_remove;
  kcm_pkg::code_t                        ram_rdata;

  kcm_ram #(
    .WIDTH (kcm_pkg::CODE_BITS),
    .DEPTH (kcm_pkg::HELD_DEPTH)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_slot),
    .wdata_i (code_q),
    .raddr_i (scan_cnt_q[kcm_pkg::HELD_IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign evt_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.fired       = out_fired_q;
  assign res_o.chord_index = out_idx_q;
  assign res_o.last_result = out_last_q;
  assign res_o.held_count  = out_hc_q;
  assign res_o.overflow    = out_ovf_q;

  assign scan_prev = scan_cnt_q - ScanCntW'(1);
  assign scan_idx  = scan_prev[kcm_pkg::HELD_IDX_W-1:0];

  // lowest free slot
  always_comb begin
    free_slot = '0;
    has_free  = 1'b0;
    for (int i = kcm_pkg::HELD_DEPTH - 1; i >= 0; i--) begin
      if (!held_valid_q[i]) begin
        free_slot = kcm_pkg::HELD_IDX_W'(i);
        has_free  = 1'b1;
      end
    end
  end

  assign do_insert = press_q && !hit_q && has_free;
  assign do_remove = !press_q && hit_q;
  assign ram_we    = (state_q == ST_UPDATE) && do_insert;

  always_comb begin
    logic [kcm_pkg::HELD_CNT_W-1:0]  held_n;
    logic [kcm_pkg::CHORD_CNT_W-1:0] cnt;
    kcm_pkg::code_t                  ccode;
    logic                            ok;
    logic [kcm_pkg::CHORD_COUNT-1:0] rest;
    logic [kcm_pkg::CHORD_IDX_W-1:0] sel;

    state_d      = state_q;
    held_valid_d = held_valid_q;
    code_d       = code_q;
    press_d      = press_q;
    scan_cnt_d   = scan_cnt_q;
    found_d      = found_q;
    hit_d        = hit_q;
    pos_d        = pos_q;
    ovf_d        = ovf_q;
    hc_d         = hc_q;
    rem_d        = rem_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_fired_d  = out_fired_q;
    out_idx_d    = out_idx_q;
    out_last_d   = out_last_q;
    out_hc_d     = out_hc_q;
    out_ovf_d    = out_ovf_q;
    held_n       = '0;
    cnt          = '0;
    ccode        = '0;
    ok           = 1'b0;
    rest         = '0;
    sel          = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (evt_i.valid) begin
          code_d     = evt_i.key_code[kcm_pkg::CODE_BITS-1:0];
          press_d    = (evt_i.key_value != '0);
          scan_cnt_d = '0;
          found_d    = '0;
          hit_d      = 1'b0;
          pos_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q != '0 && held_valid_q[scan_idx]) begin
          if (ram_rdata == code_q) begin
            hit_d = 1'b1;
            pos_d = scan_idx;
          end
          for (int i = 0; i < kcm_pkg::CHORD_COUNT; i++) begin
            for (int k = 0; k < kcm_pkg::KEYS_PER_CHORD; k++) begin
              if (chord_q[i][k*kcm_pkg::CODE_BITS +: kcm_pkg::CODE_BITS] == ram_rdata) begin
                found_d[i][k] = 1'b1;
              end
            end
          end
        end
        if (scan_cnt_q == ScanCntW'(kcm_pkg::HELD_DEPTH)) begin
          state_d = ST_UPDATE;
        end else begin
          scan_cnt_d = scan_cnt_q + ScanCntW'(1);
        end
      end
      ST_UPDATE: begin
        ovf_d = press_q && !hit_q && !has_free;
        if (do_insert) begin
          held_valid_d[free_slot] = 1'b1;
        end
        if (do_remove) begin
          held_valid_d[pos_q] = 1'b0;
        end
        for (int i = 0; i < kcm_pkg::CHORD_COUNT; i++) begin
          for (int k = 0; k < kcm_pkg::KEYS_PER_CHORD; k++) begin
            if (chord_q[i][k*kcm_pkg::CODE_BITS +: kcm_pkg::CODE_BITS] == code_q) begin
              if (do_insert) begin
                found_d[i][k] = 1'b1;
              end
              if (do_remove) begin
                found_d[i][k] = 1'b0;
              end
            end
          end
        end
        state_d = ST_MATCH;
      end
      ST_MATCH: begin
        for (int j = 0; j < kcm_pkg::HELD_DEPTH; j++) begin
          held_n = held_n + kcm_pkg::HELD_CNT_W'(held_valid_q[j]);
        end
        if (32'(held_n) > 15) begin
          hc_d = kcm_pkg::HELD_COUNT_W'(15);
        end else begin
          hc_d = kcm_pkg::HELD_COUNT_W'(held_n);
        end
        for (int i = 0; i < kcm_pkg::CHORD_COUNT; i++) begin
          cnt = chord_q[i][kcm_pkg::CHORD_CNT_LSB +: kcm_pkg::CHORD_CNT_W];
          ok  = (cnt != '0) && (32'(cnt) <= kcm_pkg::KEYS_PER_CHORD) &&
                (32'(cnt) == 32'(held_n));
          for (int k = 0; k < kcm_pkg::KEYS_PER_CHORD; k++) begin
            if (k < 32'(cnt) && !found_q[i][k]) begin
              ok = 1'b0;
            end
          end
          rem_d[i] = ok;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_hc_d    = hc_q;
          out_ovf_d   = ovf_q;
          if (rem_q == '0) begin
            out_fired_d = 1'b0;
            out_idx_d   = '0;
            out_last_d  = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            for (int i = kcm_pkg::CHORD_COUNT - 1; i >= 0; i--) begin
              if (rem_q[i]) begin
                sel = kcm_pkg::CHORD_IDX_W'(i);
              end
            end
            rest      = rem_q;
            rest[sel] = 1'b0;
            rem_d     = rest;
            out_fired_d = 1'b1;
            out_idx_d   = sel;
            out_last_d  = (rest == '0);
            if (rest == '0) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      held_valid_q <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < kcm_pkg::CHORD_COUNT; i++) begin
        chord_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i && (32'(cfg_idx_i) < kcm_pkg::CHORD_COUNT)) begin
        chord_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q      <= code_d;
    press_q     <= press_d;
    scan_cnt_q  <= scan_cnt_d;
    found_q     <= found_d;
    hit_q       <= hit_d;
    pos_q       <= pos_d;
    ovf_q       <= ovf_d;
    hc_q        <= hc_d;
    rem_q       <= rem_d;
    out_fired_q <= out_fired_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
    out_hc_q    <= out_hc_d;
    out_ovf_q   <= out_ovf_d;
  end

endmodule

>>> src/kcm_checker.sv
// kcm_checker: port-level assertions for key_chord_matcher, with its bind
// depends on kcm_pkg and key_chord_matcher

module kcm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         evt_valid_i,
  input logic                         evt_ready_i,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic                         fired_i,
  input kcm_pkg::chord_idx_t          chord_index_i,
  input logic                         last_result_i,
  input kcm_pkg::held_count_t         held_count_i,
  input logic                         overflow_i
);

  // stalled result item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(fired_i) &&
      $stable(chord_index_i) && $stable(last_result_i) && $stable(held_count_i) &&
      $stable(overflow_i))
    else $error("stalled result item changed");

  // one event at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("event taken while another is in flight");

  // a no-match item stands alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !fired_i |-> chord_index_i == '0 && last_result_i)
    else $error("no-match item malformed");

  // held count bounded by the set size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> 32'(held_count_i) <= kcm_pkg::HELD_CNT_MAX)
    else $error("held count out of range");

  // overflow only with a full set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && overflow_i |-> 32'(held_count_i) == kcm_pkg::HELD_CNT_MAX)
    else $error("overflow with free slots");

endmodule

bind key_chord_matcher kcm_checker u_kcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .evt_valid_i   (evt_i.valid),
  .evt_ready_i   (evt_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .fired_i       (res_o.fired),
  .chord_index_i (res_o.chord_index),
  .last_result_i (res_o.last_result),
  .held_count_i  (res_o.held_count),
  .overflow_i    (res_o.overflow)
);

>>> sim/kcm_chord_check.sv
`timescale 1ns / 1ps
// kcm_chord_check: key action codes for the bench, plus a checker that tracks the held set
// and chord registers, predicts each result item and compares it; depends on kcm_pkg, kcm_if

package kcm_tb_pkg;
  import kcm_pkg::*;

  typedef enum logic [KEY_VALUE_W-1:0] {
    KEY_UP     = 2'd0,
    KEY_DOWN   = 2'd1,
    KEY_REPEAT = 2'd2,
    KEY_HOLD   = 2'd3
  } key_action_e;

  typedef struct packed {
    logic        fired;
    chord_idx_t  chord_index;
    logic        last_result;
    held_count_t held_count;
    logic        overflow;
  } chord_result_t;
endpackage

module kcm_chord_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  kcm_evt_if                        evt_i,
  kcm_res_if                        res_i,
  input  logic                      cfg_we_i,
  input  logic [kcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kcm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  import kcm_pkg::*;
  import kcm_tb_pkg::*;

  logic [CFG_DATA_W-1:0] chord_reg [NUM_CHORD_REGS];
  code_t                 held_code [HELD_DEPTH];
  logic                  held_valid [HELD_DEPTH];
  chord_result_t         due_results[$];
  chord_result_t         want;
  int                    fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic int held_slot(code_t code);
    for (int i = 0; i < HELD_DEPTH; i++)
      if (held_valid[i] && held_code[i] == code) return i;
    return -1;
  endfunction

  function automatic bit chord_matches(logic [CFG_DATA_W-1:0] chord, int n_held);
    int cnt;
    cnt = int'(chord[CHORD_CNT_LSB +: CHORD_CNT_W]);
    if (cnt == 0 || cnt > KEYS_PER_CHORD || cnt != n_held) return 1'b0;
    for (int k = 0; k < KEYS_PER_CHORD; k++)
      if (k < cnt && held_slot(chord[k*CODE_BITS +: CODE_BITS]) < 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void predict_key_event(code_t code, key_value_t value);
    int            slot;
    int            free_slot;
    int            n_held;
    int            hits;
    logic          dropped;
    held_count_t   shown;
    chord_result_t r;
    dropped = 1'b0;
    slot    = held_slot(code);
    if (value != KEY_UP) begin
      if (slot < 0) begin
        free_slot = -1;
        for (int i = HELD_DEPTH - 1; i >= 0; i--)
          if (!held_valid[i]) free_slot = i;
        if (free_slot < 0) begin
          dropped = 1'b1;
        end else begin
          held_code[free_slot]  = code;
          held_valid[free_slot] = 1'b1;
        end
      end
    end else if (slot >= 0) begin
      held_valid[slot] = 1'b0;
    end
    n_held = 0;
    for (int i = 0; i < HELD_DEPTH; i++)
      if (held_valid[i]) n_held++;
    shown = (n_held > 15) ? held_count_t'(15) : held_count_t'(n_held);
    hits  = 0;
    for (int i = 0; i < CHORD_COUNT; i++) begin
      if (chord_matches(chord_reg[i], n_held)) begin
        r.fired       = 1'b1;
        r.chord_index = chord_idx_t'(i);
        r.last_result = 1'b0;
        r.held_count  = shown;
        r.overflow    = dropped;
        due_results.insert(due_results.size(), r);
        hits++;
      end
    end
    if (hits == 0) begin
      r.fired       = 1'b0;
      r.chord_index = '0;
      r.last_result = 1'b1;
      r.held_count  = shown;
      r.overflow    = dropped;
      due_results.insert(due_results.size(), r);
    end else begin
      due_results[due_results.size() - 1].last_result = 1'b1;
    end
  endfunction

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHORD_REGS; i++) chord_reg[i] = '0;
      for (int i = 0; i < HELD_DEPTH; i++) begin
        held_code[i]  = '0;
        held_valid[i] = 1'b0;
      end
      due_results.delete();
      pending_o <= 0;
    end else begin
      // results leave before the new event's items join the queue
      if (res_i.valid && res_i.ready) begin
        if (due_results.size() == 0) begin
          $error("result item with none expected");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("fired", 8'(want.fired), 8'(res_i.fired));
          check_field("chord_index", 8'(want.chord_index), 8'(res_i.chord_index));
          check_field("last_result", 8'(want.last_result), 8'(res_i.last_result));
          check_field("held_count", 8'(want.held_count), 8'(res_i.held_count));
          check_field("overflow", 8'(want.overflow), 8'(res_i.overflow));
        end
      end
      if (evt_i.valid && evt_i.ready) predict_key_event(evt_i.key_code, evt_i.key_value);
      if (cfg_we_i) chord_reg[cfg_idx_i] = cfg_data_i;
      pending_o <= due_results.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// tb_top: drives key events, chord register writes and result back-pressure into
// key_chord_matcher and gives the verdict; depends on kcm_pkg, kcm_if, kcm_chord_check

module tb_top;
  import kcm_pkg::*;
  import kcm_tb_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 34;
  localparam int POOL_SIZE     = 12;

  localparam code_t KEY_NONE  = 10'd0;
  localparam code_t KEY_TOP   = 10'd1023;
  localparam code_t KEY_E     = 10'd18;
  localparam code_t KEY_LCTRL = 10'd29;
  localparam code_t KEY_A     = 10'd30;
  localparam code_t KEY_D     = 10'd32;
  localparam code_t KEY_F     = 10'd33;
  localparam code_t KEY_G     = 10'd34;
  localparam code_t KEY_C     = 10'd46;
  localparam code_t KEY_B     = 10'd48;
  localparam code_t KEY_LALT  = 10'd56;

  localparam code_t KEY_POOL [POOL_SIZE] = '{
    KEY_NONE, KEY_TOP, KEY_E, KEY_LCTRL, KEY_A, KEY_D,
    KEY_F, KEY_C, KEY_B, KEY_LALT, 10'd125, 10'd767
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_count;
  int                    sent_count;
  int                    cycle_count;
  bit                    gaps_on;
  bit                    hold_results;
  logic [CFG_DATA_W-1:0] chord_cfg [NUM_CHORD_REGS];
  code_t                 down_keys[$];

  kcm_evt_if evt_ch ();
  kcm_res_if res_ch ();

  key_chord_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  kcm_chord_check chord_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt_ch),
    .res_i        (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** key_chord_matcher: FAILED **");
    $finish;
  end

  // result back-pressure, with one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void shuffle_keys(ref code_t q[$]);
    code_t t;
    int    j;
    for (int i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pack_chord(logic [CHORD_CNT_W-1:0] cnt,
      code_t c0, code_t c1, code_t c2, code_t c3, code_t c4, code_t c5);
    return {cnt, c5, c4, c3, c2, c1, c0};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_chord(bit proper);
    code_t                 keys[$];
    logic [CFG_DATA_W-1:0] chord;
    int                    pick;
    for (int i = 0; i < POOL_SIZE; i++) keys.insert(keys.size(), KEY_POOL[i]);
    shuffle_keys(keys);
    chord = '0;
    for (int k = 0; k < KEYS_PER_CHORD; k++) chord[k*CODE_BITS +: CODE_BITS] = keys[k];
    pick = proper ? 9 : $urandom_range(0, 9);
    if (pick == 0)
      chord[CHORD_CNT_LSB +: CHORD_CNT_W] = '0;
    else if (pick == 1)
      chord[CHORD_CNT_LSB +: CHORD_CNT_W] =
        CHORD_CNT_W'($urandom_range(KEYS_PER_CHORD + 1, 15));
    else
      chord[CHORD_CNT_LSB +: CHORD_CNT_W] = CHORD_CNT_W'($urandom_range(1, KEYS_PER_CHORD));
    return chord;
  endfunction

  task automatic send_key(input code_t code, input key_action_e action);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    evt_ch.valid     <= 1'b1;
    evt_ch.key_code  <= code;
    evt_ch.key_value <= action;
    do @(posedge clk_i); while (!evt_ch.ready);
    sent_count++;
  endtask

  task automatic press_key(input code_t code, input key_action_e action);
    send_key(code, action);
    down_keys.insert(down_keys.size(), code);
  endtask

  task automatic release_all();
    shuffle_keys(down_keys);
    while (down_keys.size() > 0) send_key(down_keys.pop_front(), KEY_UP);
  endtask

  task automatic wait_results_done();
    evt_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic load_chords();
    for (int i = 0; i < NUM_CHORD_REGS; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CFG_IDX_W'(i);
      cfg_data <= chord_cfg[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // clean slate, press the chord's keys in random order, sometimes a stray key
  task automatic play_chord(input int idx);
    code_t keys[$];
    int    cnt;
    release_all();
    cnt = int'(chord_cfg[idx][CHORD_CNT_LSB +: CHORD_CNT_W]);
    if (cnt > KEYS_PER_CHORD) cnt = KEYS_PER_CHORD;
    for (int k = 0; k < cnt; k++)
      keys.insert(keys.size(), chord_cfg[idx][k*CODE_BITS +: CODE_BITS]);
    if (cnt == 0) keys.insert(keys.size(), KEY_POOL[$urandom_range(0, POOL_SIZE - 1)]);
    shuffle_keys(keys);
    foreach (keys[k]) begin
      press_key(keys[k], key_action_e'($urandom_range(1, 3)));
      if ($urandom_range(0, 4) == 0) send_key(keys[k], KEY_REPEAT);
      if ($urandom_range(0, 9) == 0)
        press_key(KEY_POOL[$urandom_range(0, POOL_SIZE - 1)], KEY_DOWN);
    end
    if ($urandom_range(0, 1) == 0) release_all();
  endtask

  task automatic noise_key();
    code_t code;
    int    pick;
    pick = $urandom_range(0, 9);
    code = KEY_POOL[$urandom_range(0, POOL_SIZE - 1)];
    if (pick < 4) begin
      send_key(code, KEY_UP);
    end else if (pick < 7) begin
      press_key(code, key_action_e'($urandom_range(1, 3)));
    end else begin
      code = code_t'($urandom_range(0, (1 << KEY_CODE_W) - 1));
      if (pick == 9) send_key(code, KEY_UP);
      else press_key(code, key_action_e'($urandom_range(1, 3)));
    end
  endtask

  initial begin
    int target;
    bit paused;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_data         <= '0;
    evt_ch.valid     <= 1'b0;
    evt_ch.key_code  <= '0;
    evt_ch.key_value <= '0;
    gaps_on      = 1'b1;
    hold_results = 1'b0;
    sent_count   = 0;
    paused       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single key, pair, full six-key chord, unused, oversized count, repeated code,
    // same pair in other order, all ones
    chord_cfg[0] = pack_chord(4'd1, KEY_A, '0, '0, '0, '0, '0);
    chord_cfg[1] = pack_chord(4'd2, KEY_A, KEY_B, '0, '0, '0, '0);
    chord_cfg[2] = pack_chord(4'd6, KEY_NONE, KEY_TOP, KEY_C, KEY_D, KEY_E, KEY_F);
    chord_cfg[3] = '0;
    chord_cfg[4] = pack_chord(4'd7, KEY_A, '0, '0, '0, '0, '0);
    chord_cfg[5] = pack_chord(4'd2, KEY_A, KEY_A, '0, '0, '0, '0);
    chord_cfg[6] = pack_chord(4'd2, KEY_B, KEY_A, '0, '0, '0, '0);
    chord_cfg[7] = '1;
    load_chords();

    send_key(KEY_A, KEY_UP);
    press_key(KEY_A, KEY_DOWN);
    send_key(KEY_A, KEY_REPEAT);
    press_key(KEY_B, KEY_HOLD);
    release_all();
    press_key(KEY_NONE, KEY_DOWN);
    press_key(KEY_TOP, KEY_DOWN);
    press_key(KEY_C, KEY_DOWN);
    press_key(KEY_D, KEY_DOWN);
    press_key(KEY_E, KEY_DOWN);
    press_key(KEY_F, KEY_DOWN);
    press_key(KEY_LCTRL, KEY_DOWN);
    press_key(KEY_LALT, KEY_DOWN);
    send_key(KEY_G, KEY_DOWN);
    send_key(KEY_C, KEY_REPEAT);
    send_key(KEY_LCTRL, KEY_UP);
    press_key(KEY_G, KEY_DOWN);
    release_all();

    for (int p = 0; p < PHASES; p++) begin
      wait_results_done();
      for (int i = 0; i < NUM_CHORD_REGS; i++) begin
        case (p)
          1:       chord_cfg[i] = (i == 0) ? rand_chord(1'b1) : chord_cfg[0];
          2:       chord_cfg[i] = '0;
          default: chord_cfg[i] = (i > 0 && $urandom_range(0, 3) == 0) ? chord_cfg[i-1]
                                                                      : rand_chord(1'b0);
        endcase
      end
      if (p == 3) chord_cfg[NUM_CHORD_REGS-1] = '1;
      load_chords();
      gaps_on = (p != PHASES - 1);
      target  = sent_count + PHASE_ITEMS;
      if (p == 1) begin
        // every chord fires; results back up while events keep coming
        gaps_on      = 1'b0;
        hold_results = 1'b1;
        play_chord(0);
        play_chord(0);
        gaps_on = 1'b1;
      end
      while (sent_count < target) begin
        if (p == 3 && !paused && sent_count >= target - PHASE_ITEMS / 2) begin
          wait_results_done();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) play_chord($urandom_range(0, NUM_CHORD_REGS - 1));
        else noise_key();
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0)
      $display("** key_chord_matcher: PASSED **");
    else
      $display("** key_chord_matcher: FAILED **");
    $finish;
  end

endmodule
